[rtl/core/welf_pkg.sv]
// Shared constants and request and result types for the running variance block.
`default_nettype none

package welf_pkg;

    // Field and data path widths
    localparam int SAMPLE_W   = 32;
    localparam int DATA_W     = 64;
    localparam int COUNT_W    = 16;
    localparam int FRAC_SHIFT = 16;
    localparam int OUT_TDATA_W = 88;

    // Largest number of samples kept in one set
    localparam int MAX_SAMPLES = 65535;

    // Divider: two quotient bits per cycle
    localparam int DIV_DIGIT_W = 2;
    localparam int DIV_STEPS   = DATA_W / DIV_DIGIT_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // Multiplier: one four-bit digit of the serial operand per cycle
    localparam int MUL_DIGIT_W = 4;
    localparam int MUL_STEPS   = DATA_W / MUL_DIGIT_W;
    localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
    localparam int MUL_SUM_W   = DATA_W + MUL_DIGIT_W;

    // Division request: dividend over a count-sized divisor
    typedef struct packed {
        logic                 start;
        logic [DATA_W-1:0]    dividend;
        logic [COUNT_W-1:0]   divisor;
    } div_req_t;

    // Multiplication request: parallel operand times serial operand
    typedef struct packed {
        logic                 start;
        logic [DATA_W-1:0]    par_op;
        logic [DATA_W-1:0]    ser_op;
    } mul_req_t;

    // Multiplication result: product shifted down by 32, with saturation flag
    typedef struct packed {
        logic                 done;
        logic                 sat;
        logic [DATA_W-1:0]    term;
    } mul_res_t;

endpackage

`default_nettype wire

[rtl/core/welf_div.sv]
// Digit-serial restoring divider, two quotient bits per cycle.
`default_nettype none

module welf_div
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire welf_pkg::div_req_t          req,
    output logic                             done,
    output logic [welf_pkg::DATA_W-1:0]      quotient
);
    import welf_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0]     work_reg, work_next;
    logic [COUNT_W-1:0]    rem_reg, rem_next;
    logic [COUNT_W-1:0]    dvs_reg, dvs_next;

    logic [COUNT_W:0]      r1, r2, diff1, diff2;
    logic                  ge1, ge2;
    logic [COUNT_W-1:0]    rem1, rem2;

    // Two restoring steps: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        r1    = {rem_reg, work_reg[DATA_W-1]};
        diff1 = r1 - {1'b0, dvs_reg};
        ge1   = (r1 >= {1'b0, dvs_reg});
        rem1  = ge1 ? diff1[COUNT_W-1:0] : r1[COUNT_W-1:0];
        r2    = {rem1, work_reg[DATA_W-2]};
        diff2 = r2 - {1'b0, dvs_reg};
        ge2   = (r2 >= {1'b0, dvs_reg});
        rem2  = ge2 ? diff2[COUNT_W-1:0] : r2[COUNT_W-1:0];
    end

    // Load on a request, then advance one digit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            work_next = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            work_next = {work_reg[DATA_W-3:0], ge1, ge2};
            rem_next  = rem2;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = work_reg;

    // A finished division never overlaps a running one
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider reports done while still busy");

    // The remainder stays below the divisor while iterating
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < dvs_reg))
        else $error("divider remainder out of range");

    // A run started on an idle divider ends with done once all its steps are through
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        (req.start && !busy_reg) |=> ##(DIV_STEPS) done_reg)
        else $error("divider run length wrong");

endmodule

`default_nettype wire

[rtl/core/welf_mul.sv]
// Digit-serial multiplier, four bits of the serial operand per cycle.
`default_nettype none

module welf_mul
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire welf_pkg::mul_req_t    req,
    output welf_pkg::mul_res_t         res
);
    import welf_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [MUL_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DATA_W-1:0]      par_reg, par_next;
    logic [DATA_W-1:0]      ser_reg, ser_next;
    logic [DATA_W-1:0]      acc_reg, acc_next;
    logic [31:0]            low_reg, low_next;

    logic [MUL_SUM_W-1:0]   part;
    logic [MUL_SUM_W-1:0]   sum;

    // Add one partial product to the running high part
    always_comb
    begin
        part = MUL_SUM_W'(par_reg) * MUL_SUM_W'(ser_reg[MUL_DIGIT_W-1:0]);
        sum  = MUL_SUM_W'(acc_reg) + part;
    end

    // Load on a request, then shift one digit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        par_next  = par_reg;
        ser_next  = ser_reg;
        acc_next  = acc_reg;
        low_next  = low_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            par_next  = req.par_op;
            ser_next  = req.ser_op;
            acc_next  = '0;
            low_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = sum[MUL_SUM_W-1:MUL_DIGIT_W];
            low_next = {sum[MUL_DIGIT_W-1:0], low_reg[31:MUL_DIGIT_W]};
            ser_next = {{MUL_DIGIT_W{1'b0}}, ser_reg[DATA_W-1:MUL_DIGIT_W]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        par_reg <= par_next;
        ser_reg <= ser_next;
        acc_reg <= acc_next;
        low_reg <= low_next;
    end

    // Product bits 95..32; anything above bit 95 saturates
    assign res.done = done_reg;
    assign res.sat  = |acc_reg[DATA_W-1:32];
    assign res.term = {acc_reg[31:0], low_reg};

endmodule

`default_nettype wire

[rtl/core/welford_running_variance_top.sv]
// Running sample variance over sets of signed Q15.16 samples.
//
// Samples arrive on the s_ channel; s_tlast marks the last sample of a set.
// Each set yields one request on the m_ channel with the unbiased variance
// (Q32.32, saturating), the number of samples kept and an overflow flag.
// An accepted sample occupies the block while it passes through: a
// two-bit-per-cycle divider forms delta over the new count, then a four-bit
// digit multiplier forms the squared-deviation term. A sample marked last
// adds a second pass of the divider, unless the sum has saturated or at
// most one sample was kept, before its result is emitted. A sample beyond
// the set limit is dropped and sets the overflow flag.
// The result waits in an output register; the block goes on accepting the
// next set while it waits, and stalls only when a further result is ready
// before the previous one has been taken. Reset clears the count, mean,
// sum and flag and empties the output register.
`default_nettype none

module welford_running_variance_top
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [welf_pkg::SAMPLE_W-1:0]       s_tdata,  // [31:0] sample
    input  wire logic                                s_tlast,  // is_last
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [welf_pkg::OUT_TDATA_W-1:0]         m_tdata   // [63:0] variance,
                                                               // [79:64] sample_count,
                                                               // [80] overflow
);
    import welf_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_SUB  = 10'b0000000010,
        ST_ABS  = 10'b0000000100,
        ST_DIV  = 10'b0000001000,
        ST_MEAN = 10'b0000010000,
        ST_MUL  = 10'b0000100000,
        ST_ACC  = 10'b0001000000,
        ST_FIN  = 10'b0010000000,
        ST_FDIV = 10'b0100000000,
        ST_EMIT = 10'b1000000000
    } state_t;

    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    state_t                 state_reg, state_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [DATA_W-1:0]      mean_reg, mean_next;
    logic [DATA_W-1:0]      sum_reg, sum_next;
    logic                   ovf_reg, ovf_next;
    logic                   last_reg, last_next;
    logic [DATA_W-1:0]      xs_reg, xs_next;
    logic [DATA_W-1:0]      delta_reg, delta_next;
    logic [DATA_W-1:0]      dmag_reg, dmag_next;
    logic [DATA_W-1:0]      var_reg, var_next;
    logic                   mvalid_reg, mvalid_next;
    logic [DATA_W-1:0]      ovar_reg, ovar_next;
    logic [COUNT_W-1:0]     ocnt_reg, ocnt_next;
    logic                   oovf_reg, oovf_next;

    div_req_t               div_req;
    logic                   div_done;
    logic [DATA_W-1:0]      div_quo;
    mul_req_t               mul_req;
    mul_res_t               mul_res;

    logic                   in_take;
    logic                   emit_load;
    logic [DATA_W-1:0]      abs_delta;
    logic [DATA_W:0]        acc_sum;

    welf_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    welf_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .res   (mul_res)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_take   = s_tvalid && s_tready;
    assign emit_load = (state_reg == ST_EMIT) && (!mvalid_reg || m_tready);

    // Magnitude of delta and the saturating sum update
    always_comb
    begin
        abs_delta = delta_reg[DATA_W-1] ? (~delta_reg + 1'b1) : delta_reg;
        acc_sum   = {1'b0, sum_reg} + {1'b0, mul_res.term};
    end

    // Sequence one sample through divide, multiply and accumulate; finish and emit each set
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        mean_next   = mean_reg;
        sum_next    = sum_reg;
        ovf_next    = ovf_reg;
        last_next   = last_reg;
        xs_next     = xs_reg;
        delta_next  = delta_reg;
        dmag_next   = dmag_reg;
        var_next    = var_reg;
        mvalid_next = mvalid_reg;
        ovar_next   = ovar_reg;
        ocnt_next   = ocnt_reg;
        oovf_next   = oovf_reg;
        div_req     = '0;
        mul_req     = '0;

        // Drop the output request once taken
        if (mvalid_reg && m_tready)
        begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    last_next = s_tlast;
                    xs_next   = {{(DATA_W-SAMPLE_W-FRAC_SHIFT){s_tdata[SAMPLE_W-1]}},
                                 s_tdata, {FRAC_SHIFT{1'b0}}};
                    if (count_reg >= COUNT_W'(MAX_SAMPLES))
                    begin
                        ovf_next   = 1'b1;
                        state_next = s_tlast ? ST_FIN : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SUB;
                    end
                end
            end
            ST_SUB:
            begin
                delta_next = xs_reg - mean_reg;
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                dmag_next        = abs_delta;
                div_req.start    = 1'b1;
                div_req.dividend = abs_delta;
                div_req.divisor  = count_reg + 1'b1;
                state_next       = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                mean_next = delta_reg[DATA_W-1] ? (mean_reg - div_quo)
                                                : (mean_reg + div_quo);
                mul_req.start  = 1'b1;
                mul_req.par_op = dmag_reg;
                mul_req.ser_op = dmag_reg - div_quo;
                count_next     = count_reg + 1'b1;
                state_next     = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_res.done)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (mul_res.sat || acc_sum[DATA_W])
                begin
                    sum_next = ALL_ONES;
                    ovf_next = 1'b1;
                end
                else
                begin
                    sum_next = acc_sum[DATA_W-1:0];
                end
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                if (sum_reg == ALL_ONES)
                begin
                    var_next   = ALL_ONES;
                    state_next = ST_EMIT;
                end
                else if (count_reg > COUNT_W'(1))
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = sum_reg;
                    div_req.divisor  = count_reg - 1'b1;
                    state_next       = ST_FDIV;
                end
                else
                begin
                    var_next   = sum_reg;
                    state_next = ST_EMIT;
                end
            end
            ST_FDIV:
            begin
                if (div_done)
                begin
                    var_next   = div_quo;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // Load the output register once free, and clear the set
                if (emit_load)
                begin
                    mvalid_next = 1'b1;
                    ovar_next   = var_reg;
                    ocnt_next   = count_reg;
                    oovf_next   = ovf_reg;
                    count_next  = '0;
                    mean_next   = '0;
                    sum_next    = '0;
                    ovf_next    = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and set state, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            mean_reg   <= '0;
            sum_reg    <= '0;
            ovf_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            mean_reg   <= mean_next;
            sum_reg    <= sum_next;
            ovf_reg    <= ovf_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        last_reg  <= last_next;
        xs_reg    <= xs_next;
        delta_reg <= delta_next;
        dmag_reg  <= dmag_next;
        var_reg   <= var_next;
        ovar_reg  <= ovar_next;
        ocnt_reg  <= ocnt_next;
        oovf_reg  <= oovf_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-DATA_W-COUNT_W-1){1'b0}}, oovf_reg, ocnt_reg, ovar_reg};

    // The divider only finishes while the sequencer waits for it
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV || state_reg == ST_FDIV))
        else $error("divider finished outside a divide wait");

    // The multiplier only finishes while the sequencer waits for it
    a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_res.done |-> (state_reg == ST_MUL))
        else $error("multiplier finished outside the multiply wait");

    // Emitting a result starts a fresh set
    a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        emit_load |=> (count_reg == '0 && sum_reg == '0 && !ovf_reg && mvalid_reg))
        else $error("set state not cleared after emitting");

endmodule

`default_nettype wire
